// File: rtl/core/wca_pkg.sv
// Shared constants for the water cell automaton step unit.
`default_nettype none

package wca_pkg;

    localparam int DEFAULT_MAX_WIDTH  = 64;
    localparam int DEFAULT_MAX_HEIGHT = 64;

    localparam int OPCODE_W = 2;
    localparam int COORD_W  = 7;
    localparam int CELL_W   = 8;
    localparam int SIZE_W   = 7;
    localparam int SEED_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_PASS  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NONE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AIR_CODE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WATER_CODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 3'd4;

    localparam logic [SIZE_W-1:0] GRID_WIDTH_RESET  = 7'd64;
    localparam logic [SIZE_W-1:0] GRID_HEIGHT_RESET = 7'd64;
    localparam logic [CELL_W-1:0] AIR_CODE_RESET    = 8'd0;
    localparam logic [CELL_W-1:0] WATER_CODE_RESET  = 8'd1;
    localparam logic [SEED_W-1:0] SEED_RESET        = 16'd44257;
    localparam logic [SEED_W-1:0] LFSR_TAPS         = 16'hB400;

endpackage

`default_nettype wire

// File: rtl/core/wca_cell_ram.sv
// Single-port cell memory with registered read data.
`default_nettype none

module wca_cell_ram
    import wca_pkg::*;
#(
    parameter int DEPTH  = DEFAULT_MAX_WIDTH * DEFAULT_MAX_HEIGHT,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [CELL_W-1:0] wdata,
    output logic      [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem_array [DEPTH];
    logic [CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[addr] <= wdata;
        end
        rdata_reg <= mem_array[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/water_cell_automaton_step_unit.sv
// Water cell automaton step unit: cell grid memory and command sequencer.
//
// Commands arrive on the in channel (opcode, column, row, cell_value) and each
// request answers with exactly one read_value on the out channel. A write or
// an unused opcode answers the air code in the cycle after acceptance; a read
// answers the stored cell (air code outside the grid) from ST_RD_WAIT, after
// the memory read is registered. A water pass walks every cell in use, bottom
// row first, left to right, with one memory access per state on the single
// port: a read or write of the cell, its lower or side neighbor, or the write
// back. The pass answers the air code when the last cell is done.
// One request is in flight at a time. The output register holds the answer
// while out_ready is low; a new request is taken once that register is free
// or is being emptied in the same cycle.
// Reset starts a clearing pass that writes zero to all MAX_WIDTH*MAX_HEIGHT
// cells, one cell a cycle, with in_ready low. Configuration writes are taken
// at any time (cfg_ready stays high); writing the seed reloads the LFSR.
// Change configuration only while no request is outstanding.
`default_nettype none

module water_cell_automaton_step_unit
    import wca_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [OPCODE_W-1:0]   opcode,
    input  wire logic [COORD_W-1:0]    column,
    input  wire logic [COORD_W-1:0]    row,
    input  wire logic [CELL_W-1:0]     cell_value,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [CELL_W-1:0]     read_value,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [ADDR_W-1:0] STRIDE    = ADDR_W'(MAX_WIDTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_RD_WAIT = 3'd2;
    localparam logic [2:0] ST_P_RD    = 3'd3;
    localparam logic [2:0] ST_P_CELL  = 3'd4;
    localparam logic [2:0] ST_P_BELOW = 3'd5;
    localparam logic [2:0] ST_P_SIDE  = 3'd6;
    localparam logic [2:0] ST_P_WSRC  = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] y_reg, y_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic               left_reg, left_next;
    logic               rd_in_reg, rd_in_next;
    logic [SEED_W-1:0]  lfsr_reg, lfsr_next;
    logic               out_valid_reg, out_valid_next;
    logic [CELL_W-1:0]  read_value_reg, read_value_next;

    logic [SIZE_W-1:0]  grid_width_reg;
    logic [SIZE_W-1:0]  grid_height_reg;
    logic [CELL_W-1:0]  air_code_reg;
    logic [CELL_W-1:0]  water_code_reg;

    logic [SIZE_W-1:0]  eff_w, eff_h;
    logic               cmd_inside;
    logic [ADDR_W-1:0]  cmd_addr;
    logic [ADDR_W-1:0]  start_base;
    logic [ADDR_W-1:0]  cell_addr, below_addr, side_addr;
    logic               below_in, right_in, left_in;
    logic               accept, cfg_we;
    logic               adv;
    logic               go_left;
    logic [SEED_W-1:0]  lfsr_stepped;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [CELL_W-1:0]  mem_wdata;
    logic [CELL_W-1:0]  mem_rdata;

    wca_cell_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_cell_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        if (grid_width_reg == '0)
        begin
            eff_w = SIZE_W'(1);
        end
        else if (32'(grid_width_reg) > MAX_WIDTH)
        begin
            eff_w = SIZE_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = grid_width_reg;
        end
        if (grid_height_reg == '0)
        begin
            eff_h = SIZE_W'(1);
        end
        else if (32'(grid_height_reg) > MAX_HEIGHT)
        begin
            eff_h = SIZE_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = grid_height_reg;
        end
    end

    assign cmd_inside = (column < eff_w) && (row < eff_h);
    assign cmd_addr   = ADDR_W'(row) * STRIDE + ADDR_W'(column);
    assign start_base = ADDR_W'(eff_h - SIZE_W'(1)) * STRIDE;

    assign cell_addr  = base_reg + ADDR_W'(x_reg);
    assign below_addr = cell_addr + STRIDE;
    assign side_addr  = left_reg ? (cell_addr - ADDR_W'(1)) : (cell_addr + ADDR_W'(1));
    assign below_in   = ({1'b0, y_reg} + 8'd1) < {1'b0, eff_h};
    assign right_in   = ({1'b0, x_reg} + 8'd1) < {1'b0, eff_w};
    assign left_in    = (x_reg != '0);

    assign lfsr_stepped = {1'b0, lfsr_reg[SEED_W-1:1]} ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
    assign go_left      = lfsr_reg[0];

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        base_next       = base_reg;
        left_next       = left_reg;
        rd_in_next      = rd_in_reg;
        lfsr_next       = lfsr_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        read_value_next = read_value_reg;
        mem_we          = 1'b0;
        mem_addr        = cell_addr;
        mem_wdata       = air_code_reg;
        adv             = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_addr_reg;
                mem_wdata = '0;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                mem_addr = cmd_addr;
                if (accept)
                begin
                    unique case (opcode)
                        OP_WRITE:
                        begin
                            mem_we          = cmd_inside;
                            mem_wdata       = cell_value;
                            out_valid_next  = 1'b1;
                            read_value_next = air_code_reg;
                        end
                        OP_READ:
                        begin
                            rd_in_next = cmd_inside;
                            state_next = ST_RD_WAIT;
                        end
                        OP_PASS:
                        begin
                            x_next     = '0;
                            y_next     = COORD_W'(eff_h - SIZE_W'(1));
                            base_next  = start_base;
                            state_next = ST_P_RD;
                        end
                        OP_NONE:
                        begin
                            out_valid_next  = 1'b1;
                            read_value_next = air_code_reg;
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                out_valid_next  = 1'b1;
                read_value_next = rd_in_reg ? mem_rdata : air_code_reg;
                state_next      = ST_IDLE;
            end
            ST_P_RD:
            begin
                state_next = ST_P_CELL;
            end
            ST_P_CELL:
            begin
                if (mem_rdata != water_code_reg)
                begin
                    adv = 1'b1;
                end
                else if (below_in)
                begin
                    mem_addr   = below_addr;
                    state_next = ST_P_BELOW;
                end
                else
                begin
                    mem_we = 1'b1;
                    adv    = 1'b1;
                end
            end
            ST_P_BELOW:
            begin
                if (mem_rdata == air_code_reg)
                begin
                    mem_we     = 1'b1;
                    mem_addr   = below_addr;
                    mem_wdata  = water_code_reg;
                    state_next = ST_P_WSRC;
                end
                else
                begin
                    lfsr_next = lfsr_stepped;
                    left_next = go_left;
                    if (go_left ? left_in : right_in)
                    begin
                        mem_addr   = go_left ? (cell_addr - ADDR_W'(1))
                                             : (cell_addr + ADDR_W'(1));
                        state_next = ST_P_SIDE;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        adv    = 1'b1;
                    end
                end
            end
            ST_P_SIDE:
            begin
                if (mem_rdata == air_code_reg)
                begin
                    mem_we     = 1'b1;
                    mem_addr   = side_addr;
                    mem_wdata  = water_code_reg;
                    state_next = ST_P_WSRC;
                end
                else
                begin
                    adv = 1'b1;
                end
            end
            ST_P_WSRC:
            begin
                mem_we = 1'b1;
                adv    = 1'b1;
            end
        endcase

        if (adv)
        begin
            if (right_in)
            begin
                x_next     = x_reg + COORD_W'(1);
                state_next = ST_P_RD;
            end
            else if (y_reg == '0)
            begin
                out_valid_next  = 1'b1;
                read_value_next = air_code_reg;
                state_next      = ST_IDLE;
            end
            else
            begin
                x_next     = '0;
                y_next     = y_reg - COORD_W'(1);
                base_next  = base_reg - STRIDE;
                state_next = ST_P_RD;
            end
        end

        if (cfg_we && (cfg_index == CFG_RANDOM_SEED))
        begin
            lfsr_next = cfg_data[SEED_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_addr_reg    <= '0;
            out_valid_reg   <= 1'b0;
            lfsr_reg        <= SEED_RESET;
            grid_width_reg  <= GRID_WIDTH_RESET;
            grid_height_reg <= GRID_HEIGHT_RESET;
            air_code_reg    <= AIR_CODE_RESET;
            water_code_reg  <= WATER_CODE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            lfsr_reg      <= lfsr_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data[SIZE_W-1:0];
                    CFG_GRID_HEIGHT: grid_height_reg <= cfg_data[SIZE_W-1:0];
                    CFG_AIR_CODE:    air_code_reg    <= cfg_data[CELL_W-1:0];
                    CFG_WATER_CODE:  water_code_reg  <= cfg_data[CELL_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        y_reg          <= y_next;
        base_reg       <= base_next;
        left_reg       <= left_next;
        rd_in_reg      <= rd_in_next;
        read_value_reg <= read_value_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;

endmodule

`default_nettype wire

// File: rtl/core/wca_checker.sv
// Port-level checks for the water cell automaton step unit, with its bind.
`default_nettype none

module wca_checker
    import wca_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire logic [OPCODE_W-1:0]   opcode,
    input wire logic [COORD_W-1:0]    column,
    input wire logic [COORD_W-1:0]    row,
    input wire logic [CELL_W-1:0]     cell_value,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic [CELL_W-1:0]     read_value,
    input wire logic                  cfg_valid,
    input wire logic                  cfg_ready,
    input wire logic [CFG_IDX_W-1:0]  cfg_index,
    input wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_value))
        else $error("result dropped or changed while stalled");

    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid || out_ready)
        else $error("request taken while result slot is occupied");

    a_write_answer: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (opcode == OP_WRITE || opcode == OP_NONE) |=> out_valid)
        else $error("write request not answered in one cycle");

    a_read_answer: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && opcode == OP_READ |-> ##2 out_valid)
        else $error("read request not answered in two cycles");

    a_pass_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && opcode == OP_PASS |=> !in_ready && !out_valid)
        else $error("pass request did not hold off input");

endmodule

bind water_cell_automaton_step_unit wca_checker u_wca_checker (.*);

`default_nettype wire
